@@ rtl/ilst_pkg.sv @@
package ilst_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // Count must hold DEPTH itself.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Width used to compare positions, counts and cell indexes.
  localparam int unsigned POS_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_APPEND = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_kind_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cmd_kind_e              kind;
    logic [POS_W-1:0]       pos;
    logic [DATA_WIDTH-1:0]  word;
  } cmd_t;

endpackage

@@ rtl/ilst_cell.sv @@
module ilst_cell (
  input  logic                             clk_i,
  input  ilst_pkg::cmd_t                   cmd_i,
  input  logic [ilst_pkg::POS_W-1:0]       idx_i,
  input  logic [ilst_pkg::DATA_WIDTH-1:0]  left_i,
  input  logic [ilst_pkg::DATA_WIDTH-1:0]  right_i,
  output logic [ilst_pkg::DATA_WIDTH-1:0]  data_o
);

  logic [ilst_pkg::DATA_WIDTH-1:0] data_q, data_d;

  // Each cell decides locally whether to load, take a neighbor, or hold.
  always_comb begin
    data_d = data_q;
    case (cmd_i.kind)
      ilst_pkg::CMD_WRITE: begin
        if (idx_i == cmd_i.pos) data_d = cmd_i.word;
      end
      ilst_pkg::CMD_INSERT: begin
        if (idx_i == cmd_i.pos) begin
          data_d = cmd_i.word;
        end else if (idx_i > cmd_i.pos) begin
          data_d = left_i;
        end
      end
      ilst_pkg::CMD_REMOVE: begin
        if (idx_i >= cmd_i.pos) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/indexed_insert_remove_list.sv @@
// Indexed insert/remove list built as a chain of storage cells.
// A result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; every cell loads,
// shifts or holds in that cycle, and a result left waiting holds off the next request.
// Reset clears the entry count and the output valid; cell contents are
// undefined until written and are never read before that.
module indexed_insert_remove_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  position_i,
  input  logic [31:0] word_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_out_o,
  output logic [1:0]  status_o,
  output logic [4:0]  length_o,
  output logic        is_empty_o
);

  localparam int unsigned DW    = ilst_pkg::DATA_WIDTH;
  localparam int unsigned CNT_W = ilst_pkg::CNT_W;
  localparam int unsigned POS_W = ilst_pkg::POS_W;
  localparam int unsigned DEPTH = ilst_pkg::DEPTH;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  // Element count and the registered result.
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      word_out_q, word_out_d;
  logic [1:0]       status_q, status_d;
  logic [4:0]       length_q, length_d;
  logic             empty_q, empty_d;

  logic             accept;
  ilst_pkg::cmd_t   cmd;
  logic [DW-1:0]    cell_data [DEPTH];
  logic [DW-1:0]    rd_word;
  logic [63:0]      word_wide;
  logic [63:0]      rd_wide;
  logic [31:0]      cnt_wide;
  logic [POS_W-1:0] pos_x, cnt_x;
  logic             full;

  // A new transaction is taken whenever the output register is free or
  // being emptied in the same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The incoming word is zero-extended and then cut to the stored width.
  assign word_wide = {32'b0, word_in_i};
  assign pos_x     = POS_W'(position_i);
  assign cnt_x     = POS_W'(count_q);
  assign full      = (count_q == CNT_W'(DEPTH));

  // Read path: select the cell that the position names. Only entries below
  // the count are ever returned.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (pos_x == POS_W'(k)) rd_word = cell_data[IDX_W'(k)];
    end
  end
  assign rd_wide = 64'(rd_word);

  // Request decode: produce the broadcast command, the new count and the
  // result fields. A rejected request leaves the chain untouched.
  always_comb begin
    cmd.kind   = ilst_pkg::CMD_HOLD;
    cmd.pos    = pos_x;
    cmd.word   = word_wide[DW-1:0];
    count_d    = count_q;
    word_out_d = '0;
    status_d   = ilst_pkg::ST_OK;
    case (ilst_pkg::req_e'(req_type_i))
      ilst_pkg::REQ_READ: begin
        if (pos_x < cnt_x) begin
          word_out_d = rd_wide[31:0];
        end else begin
          status_d = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::REQ_WRITE: begin
        if (pos_x < cnt_x) begin
          cmd.kind = ilst_pkg::CMD_WRITE;
        end else begin
          status_d = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::REQ_INSERT: begin
        // The range check takes priority over the full check.
        if (pos_x > cnt_x) begin
          status_d = ilst_pkg::ST_RANGE;
        end else if (full) begin
          status_d = ilst_pkg::ST_FULL;
        end else begin
          cmd.kind = ilst_pkg::CMD_INSERT;
          count_d  = count_q + CNT_W'(1);
        end
      end
      ilst_pkg::REQ_REMOVE: begin
        if (pos_x < cnt_x) begin
          cmd.kind = ilst_pkg::CMD_REMOVE;
          count_d  = count_q - CNT_W'(1);
        end else begin
          status_d = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::REQ_APPEND: begin
        if (full) begin
          status_d = ilst_pkg::ST_FULL;
        end else begin
          // Append is a write at the first free slot.
          cmd.kind = ilst_pkg::CMD_WRITE;
          cmd.pos  = cnt_x;
          count_d  = count_q + CNT_W'(1);
        end
      end
      ilst_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // Undefined request codes do nothing and report success.
      end
    endcase
    if (!accept) begin
      cmd.kind = ilst_pkg::CMD_HOLD;
      count_d  = count_q;
    end
  end

  assign cnt_wide = 32'(count_d);
  assign length_d = cnt_wide[4:0];
  assign empty_d  = (count_d == '0);

  // The chain: each cell takes from its left neighbor on insert and from
  // its right neighbor on remove. The ends feed back harmless values.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    ilst_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (POS_W'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g])
    );
  end

  // Output valid: set by an accepted request, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only with an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_out_q <= word_out_d;
      status_q   <= status_d;
      length_q   <= length_d;
      empty_q    <= empty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_out_o  = word_out_q;
  assign status_o    = status_q;
  assign length_o    = length_q;
  assign is_empty_o  = empty_q;

endmodule

@@ bench/list_result_checker.sv @@
module list_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  req_type_i,
  input  logic [4:0]  position_i,
  input  logic [31:0] word_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] word_out_i,
  input  logic [1:0]  status_i,
  input  logic [4:0]  length_i,
  input  logic        is_empty_i,
  output int          mismatch_count_o,
  output int          pending_count_o,
  output int          compared_count_o
);

  localparam int unsigned IDX_W = $clog2(ilst_pkg::DEPTH);

  typedef struct packed {
    logic [31:0]       word;
    ilst_pkg::status_e status;
    logic [4:0]        length;
    logic              is_empty;
  } list_result_t;

  logic [ilst_pkg::DATA_WIDTH-1:0] stored_words [ilst_pkg::DEPTH];
  int                              stored_count;
  list_result_t                    awaited_results [$];

  // Applies one request to the shadow list and returns the result it must produce.
  function automatic list_result_t apply_request(input logic [2:0]  req,
                                                 input logic [4:0]  pos,
                                                 input logic [31:0] word);
    list_result_t res;
    int n;
    int p;
    res.word   = '0;
    res.status = ilst_pkg::ST_OK;
    n = stored_count;
    p = int'(pos);
    case (req)
      ilst_pkg::REQ_READ: begin
        if (p < n) res.word = 32'(stored_words[IDX_W'(p)]);
        else res.status = ilst_pkg::ST_RANGE;
      end
      ilst_pkg::REQ_WRITE: begin
        if (p < n) stored_words[IDX_W'(p)] = word[ilst_pkg::DATA_WIDTH-1:0];
        else res.status = ilst_pkg::ST_RANGE;
      end
      ilst_pkg::REQ_INSERT: begin
        if (p > n) begin
          res.status = ilst_pkg::ST_RANGE;
        end else if (n >= ilst_pkg::DEPTH) begin
          res.status = ilst_pkg::ST_FULL;
        end else begin
          for (int i = n; i > p; i--)
            stored_words[IDX_W'(i)] = stored_words[IDX_W'(i-1)];
          stored_words[IDX_W'(p)] = word[ilst_pkg::DATA_WIDTH-1:0];
          n++;
        end
      end
      ilst_pkg::REQ_REMOVE: begin
        if (p < n) begin
          for (int i = p; i + 1 < n; i++)
            stored_words[IDX_W'(i)] = stored_words[IDX_W'(i+1)];
          n--;
        end else begin
          res.status = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::REQ_APPEND: begin
        if (n >= ilst_pkg::DEPTH) begin
          res.status = ilst_pkg::ST_FULL;
        end else begin
          stored_words[IDX_W'(n)] = word[ilst_pkg::DATA_WIDTH-1:0];
          n++;
        end
      end
      ilst_pkg::REQ_CLEAR: n = 0;
      default: ;
    endcase
    stored_count = n;
    res.length   = n[4:0];
    res.is_empty = (n == 0);
    return res;
  endfunction

  // Results leave before new requests enter, since a result accepted at this
  // edge always belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      awaited_results.delete();
      stored_count    = 0;
      pending_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result with no request outstanding: word %h status %0d length %0d",
                     $time, word_out_i, status_i, length_i);
        end else begin
          want = awaited_results.pop_front();
          compared_count_o++;
          if (word_out_i !== want.word || status_i !== want.status ||
              length_i !== want.length || is_empty_i !== want.is_empty) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: mismatch: expected word %h status %0d length %0d empty %0b, %s",
                       $time, want.word, want.status, want.length, want.is_empty,
                       $sformatf("got word %h status %0d length %0d empty %0b",
                                 word_out_i, status_i, length_i, is_empty_i));
          end
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(apply_request(req_type_i, position_i, word_in_i));
      pending_count_o = awaited_results.size();
    end
  end

endmodule

@@ bench/tb_indexed_insert_remove_list.sv @@
module tb_indexed_insert_remove_list;

  // The two request codes that the block treats as no operation.
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  // Length of the long output hold-off, in cycles.
  localparam int HOLD_CYCLES = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  req_type_i;
  logic [4:0]  position_i;
  logic [31:0] word_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] word_out_o;
  logic [1:0]  status_o;
  logic [4:0]  length_o;
  logic        is_empty_o;

  int mismatch_count;
  int pending_count;
  int compared_count;

  // Idle percentages for the sender and the receiver; the stimulus process
  // changes them from phase to phase.
  int gap_pct;
  int stall_pct;

  // The stimulus process bumps hold_req to ask for one long hold-off; the
  // receiver process alone counts the cycles of it.
  int hold_req;
  int hold_ack;
  int hold_left;

  // Random requests alternate between stretches that mostly grow the list
  // and stretches that mostly shrink it, so that both the full and the empty
  // ends are visited many times.
  bit growing;
  int random_sent;
  int op_sent [8];

  indexed_insert_remove_list uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .word_in_i   (word_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_out_o  (word_out_o),
    .status_o    (status_o),
    .length_o    (length_o),
    .is_empty_o  (is_empty_o)
  );

  list_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .word_in_i        (word_in_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .word_out_i       (word_out_o),
    .status_i         (status_o),
    .length_i         (length_o),
    .is_empty_i       (is_empty_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .compared_count_o (compared_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver: stalls at random at the current rate, except during a
  // requested hold-off, when ready stays low for the whole stretch.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one transaction and returns at the edge that accepts it. Readiness
  // is looked at on the falling edge, where every signal has settled, and
  // nothing changes before the next rising edge. Valid stays high on return,
  // so back-to-back transactions keep it high without a drop.
  task automatic send_request(input logic [2:0] req, input logic [4:0] pos,
                              input logic [31:0] word);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    word_in_i  <= word;
    op_sent[req]++;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic send_random();
    int roll;
    logic [2:0]  req;
    logic [4:0]  pos;
    logic [31:0] word;
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 30) req = ilst_pkg::REQ_APPEND;
      else if (roll < 60) req = ilst_pkg::REQ_INSERT;
      else if (roll < 72) req = ilst_pkg::REQ_READ;
      else if (roll < 84) req = ilst_pkg::REQ_WRITE;
      else if (roll < 95) req = ilst_pkg::REQ_REMOVE;
      else if (roll < 97) req = ilst_pkg::REQ_CLEAR;
      else req = roll[0] ? REQ_UNUSED_7 : REQ_UNUSED_6;
    end else begin
      if (roll < 40) req = ilst_pkg::REQ_REMOVE;
      else if (roll < 55) req = ilst_pkg::REQ_READ;
      else if (roll < 70) req = ilst_pkg::REQ_WRITE;
      else if (roll < 80) req = ilst_pkg::REQ_INSERT;
      else if (roll < 90) req = ilst_pkg::REQ_APPEND;
      else if (roll < 94) req = ilst_pkg::REQ_CLEAR;
      else req = roll[0] ? REQ_UNUSED_7 : REQ_UNUSED_6;
    end
    // Positions lean toward the low end, where they are most often in range;
    // a few cover the whole field, the top bit included.
    if ($urandom_range(0, 99) < 85) pos = 5'($urandom_range(0, $urandom_range(0, 16)));
    else pos = 5'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 10) word = '0;
    else if (roll < 20) word = '1;
    else word = $urandom;
    send_request(req, pos, word);
    random_sent++;
    if (random_sent % 40 == 0) growing = !growing;
  endtask

  // Stops offering and waits until every outstanding result has been taken.
  // The falling edge lets the checker record the last accepted request first.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (pending_count == 0);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = ilst_pkg::REQ_READ;
    position_i  = '0;
    word_in_i   = '0;
    out_ready_i = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    hold_req    = 0;
    hold_ack    = 0;
    hold_left   = 0;
    growing     = 1'b1;
    random_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Accesses to an empty list, including an insert past the
    // end, must all fail with the range status.
    send_request(ilst_pkg::REQ_READ, 5'd0, 32'h0);
    send_request(ilst_pkg::REQ_REMOVE, 5'd0, 32'h0);
    send_request(ilst_pkg::REQ_INSERT, 5'd1, 32'hDEAD_BEEF);
    // Fill the list to capacity; odd slots get all ones, even slots their index.
    for (int k = 0; k < ilst_pkg::DEPTH; k++)
      send_request(ilst_pkg::REQ_APPEND, 5'(k), k[0] ? 32'hFFFF_FFFF : 32'(k));
    // A full list refuses append and insert, but an insert beyond the end is
    // reported as out of range, since that check comes first.
    send_request(ilst_pkg::REQ_APPEND, 5'd0, 32'h1234_5678);
    send_request(ilst_pkg::REQ_INSERT, 5'd16, 32'h1234_5678);
    send_request(ilst_pkg::REQ_INSERT, 5'd17, 32'h1234_5678);
    send_request(ilst_pkg::REQ_WRITE, 5'd15, 32'hA5A5_5A5A);
    send_request(ilst_pkg::REQ_READ, 5'd15, 32'h0);
    send_request(ilst_pkg::REQ_READ, 5'd31, 32'h0);
    // Remove the last and the first entry, then insert at the head.
    send_request(ilst_pkg::REQ_REMOVE, 5'd15, 32'h0);
    send_request(ilst_pkg::REQ_REMOVE, 5'd0, 32'h0);
    send_request(ilst_pkg::REQ_INSERT, 5'd0, 32'h8000_0001);
    send_request(ilst_pkg::REQ_READ, 5'd1, 32'h0);
    // A write at the count is out of range; an insert there lands at the end.
    send_request(ilst_pkg::REQ_WRITE, 5'd15, 32'h0);
    send_request(ilst_pkg::REQ_INSERT, 5'd15, 32'h7FFF_FFFE);
    send_request(REQ_UNUSED_6, 5'd3, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED_7, 5'd31, 32'hFFFF_FFFF);
    send_request(ilst_pkg::REQ_CLEAR, 5'd0, 32'h0);
    send_request(ilst_pkg::REQ_READ, 5'd0, 32'h0);

    // Random part in four idling mixes: none, sender gaps, receiver stalls,
    // and light idling on both sides.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 69; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 69; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      repeat (165) send_random();

      // After the first mix, hold the output off for a long stretch while
      // requests keep coming, so the block fills and drops its input ready,
      // then pause the sender until every result is back.
      if (phase == 0) begin
        hold_req++;
        repeat (24) send_random();
        wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d reads, %0d writes, %0d inserts, %0d removes, %0d appends, %0d clears",
             op_sent[ilst_pkg::REQ_READ], op_sent[ilst_pkg::REQ_WRITE],
             op_sent[ilst_pkg::REQ_INSERT], op_sent[ilst_pkg::REQ_REMOVE],
             op_sent[ilst_pkg::REQ_APPEND], op_sent[ilst_pkg::REQ_CLEAR]);
    $display("and %0d unused codes; %0d results compared under four idling mixes and a hold-off",
             op_sent[REQ_UNUSED_6] + op_sent[REQ_UNUSED_7], compared_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // This watchdog allows far more time than a correct run needs.
  initial begin
    #(12 * 200000);
    $display("simulation failed");
    $finish;
  end

endmodule
